### sv/rgbhls_pkg.sv
// ----------------------------------------------------------------------------
// rgbhls_pkg
// Shared constants for the RGB to HLS converter.
// ----------------------------------------------------------------------------
package rgbhls_pkg;
  localparam int RGBHLS_COMPONENT_BITS = 16;
  localparam int RGBHLS_GUARD_BITS     = 3;
endpackage

### sv/rgbhls_if.sv
// ----------------------------------------------------------------------------
// rgbhls_if
// Valid/ready channel carrying three components of one pixel.
// ----------------------------------------------------------------------------
interface rgbhls_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] c0;
  logic [W-1:0] c1;
  logic [W-1:0] c2;

  modport source (output valid, output c0, output c1, output c2, input ready);
  modport sink   (input valid, input c0, input c1, input c2, output ready);
endinterface

### sv/rgb_to_hls_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hls_converter
// Throughput: one pixel per cycle while the output is not stalled; the two W-stage dividers set the depth.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_to_hls_converter
  import rgbhls_pkg::*;
#(
  parameter int COMPONENT_BITS = RGBHLS_COMPONENT_BITS
) (
  input  logic  clk,
  input  logic  rst_n,
  rgbhls_if.sink   in_px,
  rgbhls_if.source out_px
);
  localparam int W  = COMPONENT_BITS;
  localparam int DW = W + RGBHLS_GUARD_BITS;
  localparam int NW = W + 4;
  localparam logic [W+1:0] TWO_FULL = {1'b0, {W{1'b1}}, 1'b0};

  logic en;
  logic out_valid_r;

  logic         v0_r;
  logic [W-1:0] r0_r, g0_r, b0_r;

  logic         v1_r;
  logic [W-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  logic [W-1:0] mx1_nxt, mn1_nxt;

  logic          v2_r, gray2_r;
  logic [W-1:0]  light2_r;
  logic [DW-1:0] hnum_r, hdiv_r, snum_r, sdiv_r;
  logic [W-1:0]  slo_r;
  logic [W-1:0]  delta;
  logic [W:0]    sum;
  logic [W+1:0]  den;
  logic signed [NW-1:0] n, d6;
  logic [2*W-1:0] satn;

  logic         vl_r [W];
  logic         gl_r [W];
  logic [W-1:0] ll_r [W];

  logic [W-1:0] hq, sq;
  logic [W-1:0] hue_r, light_r, sat_r;

  assign en = !out_valid_r || out_px.ready;
  assign in_px.ready = en;

  always_comb begin
    mx1_nxt = r0_r;
    if (g0_r > mx1_nxt) mx1_nxt = g0_r;
    if (b0_r > mx1_nxt) mx1_nxt = b0_r;
    mn1_nxt = r0_r;
    if (g0_r < mn1_nxt) mn1_nxt = g0_r;
    if (b0_r < mn1_nxt) mn1_nxt = b0_r;
  end

  always_comb begin
    delta = mx1_r - mn1_r;
    sum   = {1'b0, mx1_r} + {1'b0, mn1_r};
    if (sum <= {1'b0, {W{1'b1}}}) den = {1'b0, sum};
    else                          den = TWO_FULL - {1'b0, sum};
    d6 = NW'({delta, 2'b00}) + NW'({delta, 1'b0});
    if (r1_r == mx1_r)
      n = NW'(g1_r) - NW'(b1_r);
    else if (g1_r == mx1_r)
      n = NW'({delta, 1'b0}) + NW'(b1_r) - NW'(r1_r);
    else
      n = NW'({delta, 2'b00}) + NW'(r1_r) - NW'(g1_r);
    if (n < 0) n = n + d6;
    satn = {delta, {W{1'b0}}} - (2*W)'(delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < W; k++) vl_r[k] <= 1'b0;
    end else if (en) begin
      v0_r <= in_px.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      vl_r[0] <= v2_r;
      for (int k = 1; k < W; k++) vl_r[k] <= vl_r[k-1];
      out_valid_r <= vl_r[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= in_px.c0;
      g0_r <= in_px.c1;
      b0_r <= in_px.c2;
      r1_r <= r0_r;
      g1_r <= g0_r;
      b1_r <= b0_r;
      mx1_r <= mx1_nxt;
      mn1_r <= mn1_nxt;
      gray2_r  <= (delta == '0);
      light2_r <= sum[W:1];
      hnum_r   <= DW'(n);
      hdiv_r   <= DW'(d6);
      snum_r   <= DW'(satn[2*W-1:W]);
      slo_r    <= satn[W-1:0];
      sdiv_r   <= DW'(den);
      gl_r[0] <= gray2_r;
      ll_r[0] <= light2_r;
      for (int k = 1; k < W; k++) begin
        gl_r[k] <= gl_r[k-1];
        ll_r[k] <= ll_r[k-1];
      end
      hue_r   <= gl_r[W-1] ? '0 : hq;
      sat_r   <= gl_r[W-1] ? '0 : sq;
      light_r <= ll_r[W-1];
    end
  end

  rgbhls_div #(.W(W), .DW(DW)) u_hue_div (
    .clk(clk), .en(en), .num_hi(hnum_r), .num_lo('0), .dvs(hdiv_r), .quo(hq)
  );

  rgbhls_div #(.W(W), .DW(DW)) u_sat_div (
    .clk(clk), .en(en), .num_hi(snum_r), .num_lo(slo_r), .dvs(sdiv_r), .quo(sq)
  );

  assign out_px.valid = out_valid_r;
  assign out_px.c0    = hue_r;
  assign out_px.c1    = light_r;
  assign out_px.c2    = sat_r;
endmodule

### sv/rgbhls_div.sv
// ----------------------------------------------------------------------------
// rgbhls_div
// Pipelined restoring divider, one quotient bit per stage, W stages.
// ----------------------------------------------------------------------------
module rgbhls_div
  import rgbhls_pkg::*;
#(
  parameter int W  = RGBHLS_COMPONENT_BITS,
  parameter int DW = RGBHLS_COMPONENT_BITS + RGBHLS_GUARD_BITS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num_hi,
  input  logic [W-1:0]  num_lo,
  input  logic [DW-1:0] dvs,
  output logic [W-1:0]  quo
);
  logic [DW-1:0] rem_r [W];
  logic [W-1:0]  lo_r  [W];
  logic [DW-1:0] dv_r  [W];
  logic [DW-1:0] rem_nxt [W];
  logic [W-1:0]  lo_nxt  [W];
  logic [DW-1:0] dv_nxt  [W];

  always_comb begin
    logic [DW-1:0] rem_i;
    logic [W-1:0]  lo_i;
    logic [DW:0]   t;
    for (int k = 0; k < W; k++) begin
      rem_i = (k == 0) ? num_hi : rem_r[(k == 0) ? 0 : k-1];
      lo_i  = (k == 0) ? num_lo : lo_r[(k == 0) ? 0 : k-1];
      dv_nxt[k] = (k == 0) ? dvs : dv_r[(k == 0) ? 0 : k-1];
      t = {rem_i, lo_i[W-1]};
      if (t >= {1'b0, dv_nxt[k]}) begin
        rem_nxt[k] = DW'(t - {1'b0, dv_nxt[k]});
        lo_nxt[k]  = {lo_i[W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[DW-1:0];
        lo_nxt[k]  = {lo_i[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        dv_r[k]  <= dv_nxt[k];
      end
    end
  end

  assign quo = lo_r[W-1];
endmodule

### sv/rgbhls_checker.sv
// ----------------------------------------------------------------------------
// rgbhls_checker
// Port-level checks for the RGB to HLS converter.
// ----------------------------------------------------------------------------
module rgbhls_checker
  import rgbhls_pkg::*;
#(
  parameter int W = RGBHLS_COMPONENT_BITS
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_hue,
  input logic [W-1:0] out_sat
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped under stall");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_gray_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat == '0 |-> out_hue == '0)
    else $error("zero saturation with nonzero hue");
endmodule

bind rgb_to_hls_converter rgbhls_checker #(.W(COMPONENT_BITS)) u_rgbhls_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_px.ready),
  .out_valid(out_px.valid),
  .out_ready(out_px.ready),
  .out_hue(out_px.c0),
  .out_sat(out_px.c2)
);

### tb/tb_rgb_to_hls_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hls_converter
// Drives RGB pixels into the converter under random source and sink idling
// and checks every hue, lightness and saturation against a local predictor.
// ----------------------------------------------------------------------------
module tb_rgb_to_hls_converter
  import rgbhls_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = RGBHLS_COMPONENT_BITS;
  localparam logic [CB-1:0] FULL = '1;
  localparam int LATENCY = CB + 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic [CB-1:0] lightness;
    logic [CB-1:0] saturation;
  } hls_t;

  class hls_scoreboard;
    hls_t pending[$];
    int   errors;
    int   checked;

    function hls_t convert(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      hls_t   res;
      longint mx, mn, sum, delta, den, sat, n;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      sum = mx + mn;
      delta = mx - mn;
      res.lightness = CB'(sum >> 1);
      res.hue = '0;
      res.saturation = '0;
      if (delta != 0) begin
        den = (sum <= FULL) ? sum : 2 * longint'(FULL) - sum;
        sat = (den != 0) ? (delta * FULL) / den : FULL;
        if (sat > FULL) sat = FULL;
        if (r == mx) n = longint'(g) - longint'(b);
        else if (g == mx) n = 2 * delta + longint'(b) - longint'(r);
        else n = 4 * delta + longint'(r) - longint'(g);
        if (n < 0) n += 6 * delta;
        if (n >= 6 * delta) n -= 6 * delta;
        res.hue = CB'((n << CB) / (6 * delta));
        res.saturation = CB'(sat);
      end
      return res;
    endfunction

    function void note_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      pending.push_back(convert(r, g, b));
    endfunction

    function void check_result(hls_t got);
      hls_t exp_res;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result hue=%0d lightness=%0d saturation=%0d",
               got.hue, got.lightness, got.saturation);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.hue !== exp_res.hue) begin
        $error("hue: expected %0d, got %0d", exp_res.hue, got.hue);
        errors++;
      end
      if (got.lightness !== exp_res.lightness) begin
        $error("lightness: expected %0d, got %0d", exp_res.lightness, got.lightness);
        errors++;
      end
      if (got.saturation !== exp_res.saturation) begin
        $error("saturation: expected %0d, got %0d", exp_res.saturation, got.saturation);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   sent = 0;
  int   quiet_cycles = 0;
  hls_scoreboard hls_sb = new();

  rgbhls_if #(.W(CB)) in_px ();
  rgbhls_if #(.W(CB)) out_px ();

  rgb_to_hls_converter #(.COMPONENT_BITS(CB)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_px (in_px.sink),
    .out_px(out_px.source)
  );

  always #5 clk = ~clk;

  initial begin
    in_px.valid = 1'b0;
    in_px.c0 = '0;
    in_px.c1 = '0;
    in_px.c2 = '0;
    out_px.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_px.valid && in_px.ready)
      hls_sb.note_pixel(in_px.c0, in_px.c1, in_px.c2);
    if (rst_n && out_px.valid && out_px.ready)
      hls_sb.check_result({out_px.c0, out_px.c1, out_px.c2});
  end

  always @(negedge clk)
    out_px.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_rgb_to_hls_converter: errors");
      $finish;
    end
  end

  task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_px.valid <= 1'b0;
      @(negedge clk);
    end
    in_px.valid <= 1'b1;
    in_px.c0 <= r;
    in_px.c1 <= g;
    in_px.c2 <= b;
    do @(posedge clk); while (!in_px.ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(5))
      0: return '0;
      1: return FULL;
      2: return CB'($urandom_range(15));
      3: return FULL - CB'($urandom_range(15));
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [CB-1:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = rand_comp();
      g = rand_comp();
      b = rand_comp();
      case ($urandom_range(7))
        0: g = r;
        1: b = g;
        2: begin g = r; b = r; end
        3: b = r;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    in_px.valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(FULL, FULL, FULL);
    send_pixel(16'h8000, 16'h8000, 16'h8000);
    send_pixel(FULL, 16'h0000, 16'h0000);
    send_pixel(16'h0000, FULL, 16'h0000);
    send_pixel(16'h0000, 16'h0000, FULL);
    send_pixel(FULL, FULL, 16'h0000);
    send_pixel(16'h0000, FULL, FULL);
    send_pixel(FULL, 16'h0000, FULL);
    send_pixel(FULL, 16'h0000, 16'h0001);
    send_pixel(16'h0001, 16'h0000, 16'h0000);
    send_pixel(FULL, FULL - 16'h0001, FULL - 16'h0001);
    send_pixel(16'h7FFF, 16'h8000, 16'h0000);
    send_pixel(16'h8000, 16'h7FFF, 16'h0000);
    send_pixel(16'h1234, 16'hFEDC, 16'hFEDC);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    send_pixel(16'h5555, 16'hAAAA, FULL);
    send_pixel(16'h0001, 16'h0002, 16'h0003);
    send_pixel(16'h0003, 16'h0002, 16'h0001);

    src_idle_pct = 7;
    snk_idle_pct = 62;
    send_random(550);
    src_idle_pct = 62;
    snk_idle_pct = 7;
    send_random(550);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(530);

    while (hls_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    $display("covered %0d pixels: gray, primaries, ties and random mixes", sent);
    $display("checked %0d results under source and sink stalls", hls_sb.checked);
    if (hls_sb.errors == 0)
      $display("tb_rgb_to_hls_converter: clean");
    else
      $display("tb_rgb_to_hls_converter: errors");
    $finish;
  end
endmodule
